### src/srtn_pkg.sv
`timescale 1ns / 1ps

package srtn_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int TIME_W        = 21;
  localparam int SLOT_W        = 4;
  localparam int KIND_W        = 2;

  localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_TAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] remain;
    logic [TIME_W-1:0]  resp;
  } rec_t;

  typedef struct packed {
    logic start;
    logic cand_vld;
    logic cand_ok;
  } pick_ctl_t;

endpackage

### src/srtn_rec_mem.sv
`timescale 1ns / 1ps

module srtn_rec_mem
  import srtn_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [MAX_PROCS];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/srtn_pick.sv
`timescale 1ns / 1ps

module srtn_pick
  import srtn_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pick_ctl_t         ctl,
  input  logic [TIME_W-1:0] now,
  input  rec_t              cand_rec,
  input  logic [IDX_W-1:0]  cand_idx,
  output logic              have_best,
  output rec_t              best_rec,
  output logic [IDX_W-1:0]  best_idx
);

  logic             have_best_r, have_best_nxt;
  rec_t             best_rec_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             take;

  always_comb begin
    take = ctl.cand_vld && ctl.cand_ok &&
           (TIME_W'(cand_rec.arrival) <= now) &&
           (!have_best_r ||
            (cand_rec.remain < best_rec_r.remain) ||
            ((cand_rec.remain == best_rec_r.remain) &&
             (cand_rec.arrival < best_rec_r.arrival)));
    have_best_nxt = have_best_r;
    if (ctl.start) begin
      have_best_nxt = 1'b0;
    end else if (take) begin
      have_best_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_rec_r <= cand_rec;
      best_idx_r <= cand_idx;
    end
  end

  assign have_best = have_best_r;
  assign best_rec  = best_rec_r;
  assign best_idx  = best_idx_r;

endmodule

### src/srtn_cpu_scheduler.sv
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time scheduler over a table of MAX_PROCS process slots.
// A load item (kind 0) stores arrival and burst in the next free slot; a zero burst or a
// full table drops it. A clear item (kind 2) empties the table and zeroes the clock; kind 3
// is dropped. Neither gives a result. A tick item (kind 1) scans every slot: the slot
// records sit in one memory that is read one slot per cycle into a single compare unit
// that keeps the best candidate, then the chosen slot is written back and the timing
// figures are formed in two more steps. Each tick gives one result item, which waits in an
// output register; loads and clears are still taken while it waits. No clearing pass runs
// after reset.
module srtn_cpu_scheduler
  import srtn_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [FIELD_W-1:0] in_arrival_time,
  input  logic [FIELD_W-1:0] in_burst_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLOT_W-1:0]  out_ran_slot,
  output logic               out_idle,
  output logic               out_finished,
  output logic [TIME_W-1:0]  out_clock_after,
  output logic [TIME_W-1:0]  out_completion_time,
  output logic [TIME_W-1:0]  out_turnaround_time,
  output logic [TIME_W-1:0]  out_waiting_time,
  output logic [TIME_W-1:0]  out_response_time,
  output logic               out_all_done
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     issue_idx_r, issue_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]     loaded_count_r, loaded_count_nxt;
  logic [CNT_W-1:0]     finished_count_r, finished_count_nxt;
  logic [TIME_W-1:0]    clock_r, clock_nxt;
  logic [MAX_PROCS-1:0] started_r, started_nxt;
  logic [MAX_PROCS-1:0] finished_r, finished_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [TIME_W-1:0]    resp_r;
  logic                 fin_r;
  logic [TIME_W-1:0]    tat_r;

  logic [SLOT_W-1:0]    out_ran_slot_r;
  logic                 out_idle_r;
  logic                 out_finished_r;
  logic [TIME_W-1:0]    out_clock_after_r;
  logic [TIME_W-1:0]    out_completion_time_r;
  logic [TIME_W-1:0]    out_turnaround_time_r;
  logic [TIME_W-1:0]    out_waiting_time_r;
  logic [TIME_W-1:0]    out_response_time_r;
  logic                 out_all_done_r;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  rec_t                 wr_data;
  rec_t                 rd_data;
  pick_ctl_t            pick_ctl;
  logic                 have_best;
  rec_t                 best_rec;
  logic [IDX_W-1:0]     best_idx;

  logic                 upd_ld, tat_ld, emit_ld;
  logic [FIELD_W-1:0]   rem_new;
  logic [TIME_W-1:0]    resp_new;
  logic [TIME_W-1:0]    wait_val;
  logic [IDX_W-1:0]     load_idx;

  srtn_rec_mem #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (issue_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  srtn_pick #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .now       (clock_r),
    .cand_rec  (rd_data),
    .cand_idx  (rd_idx_r),
    .have_best (have_best),
    .best_rec  (best_rec),
    .best_idx  (best_idx)
  );

  assign load_idx = loaded_count_r[IDX_W-1:0];
  assign rem_new  = best_rec.remain - FIELD_W'(1);
  assign resp_new = started_r[best_idx] ? best_rec.resp
                                        : clock_r - TIME_W'(best_rec.arrival);
  assign wait_val = (tat_r >= TIME_W'(best_rec.burst)) ? tat_r - TIME_W'(best_rec.burst)
                                                       : '0;

  always_comb begin
    state_nxt          = state_r;
    issue_idx_nxt      = issue_idx_r;
    rd_vld_nxt         = rd_vld_r;
    rd_idx_nxt         = rd_idx_r;
    loaded_count_nxt   = loaded_count_r;
    finished_count_nxt = finished_count_r;
    clock_nxt          = clock_r;
    started_nxt        = started_r;
    finished_nxt       = finished_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    in_ready           = (state_r == ST_IDLE);
    wr_en              = 1'b0;
    wr_addr            = load_idx;
    wr_data            = '{arrival: in_arrival_time, burst: in_burst_time,
                           remain: in_burst_time, resp: '0};
    pick_ctl           = '0;
    upd_ld             = 1'b0;
    tat_ld             = 1'b0;
    emit_ld            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_LOAD: begin
              if ((in_burst_time != '0) && (loaded_count_r < CNT_MAX)) begin
                wr_en                  = 1'b1;
                started_nxt[load_idx]  = 1'b0;
                finished_nxt[load_idx] = 1'b0;
                loaded_count_nxt       = loaded_count_r + CNT_W'(1);
              end
            end
            KIND_TICK: begin
              issue_idx_nxt  = '0;
              pick_ctl.start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            KIND_CLEAR: begin
              loaded_count_nxt   = '0;
              finished_count_nxt = '0;
              clock_nxt          = '0;
              started_nxt        = '0;
              finished_nxt       = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        pick_ctl.cand_vld = rd_vld_r;
        pick_ctl.cand_ok  = (CNT_W'(rd_idx_r) < loaded_count_r) && !finished_r[rd_idx_r];
        if (issue_idx_r < CNT_MAX) begin
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = issue_idx_r[IDX_W-1:0];
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end else begin
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        upd_ld    = 1'b1;
        clock_nxt = (clock_r == CLOCK_MAX) ? clock_r : clock_r + TIME_W'(1);
        if (have_best) begin
          wr_en                 = 1'b1;
          wr_addr               = best_idx;
          wr_data               = '{arrival: best_rec.arrival, burst: best_rec.burst,
                                    remain: rem_new, resp: resp_new};
          started_nxt[best_idx] = 1'b1;
          if (rem_new == '0) begin
            finished_nxt[best_idx] = 1'b1;
            finished_count_nxt     = finished_count_r + CNT_W'(1);
          end
        end
        state_nxt = ST_TAT;
      end
      ST_TAT: begin
        tat_ld    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit_ld       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      issue_idx_r      <= '0;
      rd_vld_r         <= 1'b0;
      rd_idx_r         <= '0;
      loaded_count_r   <= '0;
      finished_count_r <= '0;
      clock_r          <= '0;
      started_r        <= '0;
      finished_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      issue_idx_r      <= issue_idx_nxt;
      rd_vld_r         <= rd_vld_nxt;
      rd_idx_r         <= rd_idx_nxt;
      loaded_count_r   <= loaded_count_nxt;
      finished_count_r <= finished_count_nxt;
      clock_r          <= clock_nxt;
      started_r        <= started_nxt;
      finished_r       <= finished_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_ld) begin
      resp_r <= resp_new;
      fin_r  <= have_best && (rem_new == '0);
    end
    if (tat_ld) begin
      tat_r <= clock_r - TIME_W'(best_rec.arrival);
    end
    if (emit_ld) begin
      out_ran_slot_r        <= have_best ? SLOT_W'(best_idx) : '0;
      out_idle_r            <= !have_best;
      out_finished_r        <= fin_r;
      out_clock_after_r     <= clock_r;
      out_completion_time_r <= fin_r ? clock_r : '0;
      out_turnaround_time_r <= fin_r ? tat_r : '0;
      out_waiting_time_r    <= fin_r ? wait_val : '0;
      out_response_time_r   <= fin_r ? resp_r : '0;
      out_all_done_r        <= (finished_count_r == loaded_count_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ran_slot        = out_ran_slot_r;
  assign out_idle            = out_idle_r;
  assign out_finished        = out_finished_r;
  assign out_clock_after     = out_clock_after_r;
  assign out_completion_time = out_completion_time_r;
  assign out_turnaround_time = out_turnaround_time_r;
  assign out_waiting_time    = out_waiting_time_r;
  assign out_response_time   = out_response_time_r;
  assign out_all_done        = out_all_done_r;

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_TICK) |=> !in_ready)
    else $error("tick item accepted without leaving idle");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    finished_count_r <= loaded_count_r)
    else $error("more finished processes than loaded");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> !rd_vld_r)
    else $error("slot read still in flight at update");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_finished && (out_ran_slot == '0))
    else $error("idle tick reports a process");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_waiting_time <= out_turnaround_time)
    else $error("waiting time exceeds turnaround time");

endmodule
